### rtl/rsk_pkg.sv
// shared types and constants for the record sort engine
package rsk_pkg;

   localparam int MAX_RECORDS = 64;

   localparam int KEY_W = 32;
   localparam int TAG_W = 16;

   typedef struct packed {
      logic [KEY_W-1:0] price_key;
      logic [TAG_W-1:0] record_tag;
      logic             last_item;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] sorted_key;
      logic [TAG_W-1:0] sorted_tag;
      logic             last_out;
      logic             dropped;
   } rsp_type;

   // contents of one cell of the chain
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   // control broadcast to every cell
   typedef struct packed {
      logic             insert;
      logic             shift;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } cell_ctl_type;

endpackage

### rtl/record_sort_by_key.sv
// top level of the record sort engine: cell chain, drain control, output register
//
// records enter one request per cycle into a chain of MAX_RECORDS cells that
// is kept in ascending key order at all times: every cell compares its key
// with the incoming one, and the cells above the insertion point move one place
// up in the same cycle. equal keys keep arrival order. the request marked last
// (inserted too, if there is room) starts the drain: cell 0 moves into the
// output register and the chain shifts down, one result per cycle while the
// result side does not stall, so every stored record of the set gives one
// result. requests are stalled during the drain and accepted again from the
// cycle after the final result is loaded, even while that result still waits
// in the output register. records that arrive while all cells are full are
// discarded and every result of that set carries dropped. no clearing pass is
// needed after reset.
module record_sort_by_key import rsk_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   entry_type    entries [MAX_RECORDS];
   logic         stays   [MAX_RECORDS];
   cell_ctl_type ctl;

   logic    draining_ff, draining_in;
   logic    overflow_ff, overflow_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic req_take;
   logic rsp_take;
   logic full;
   logic final_load;

   // request side: stalled only while a set drains
   assign req_stall = draining_ff;
   assign req_take  = req_valid && !draining_ff;
   assign full      = entries[MAX_RECORDS-1].valid;

   // during a drain, the output register loads whenever it is empty or being emptied
   assign rsp_take   = draining_ff && (!rsp_valid_ff || !rsp_stall);
   // valid cells form a prefix, so cell 1 empty means cell 0 is the final one
   assign final_load = rsp_take && !entries[1].valid;

   assign ctl.insert = req_take && !full;
   assign ctl.shift  = rsp_take;
   assign ctl.key    = req_data.price_key;
   assign ctl.tag    = req_data.record_tag;

   // the chain: cell 0 takes the new record on an insert when its own stays is low
   for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
      entry_type prev_e, next_e;
      logic      prev_s;
      if (i == 0) begin : g_first
         assign prev_e = '0;
         assign prev_s = 1'b1;
      end else begin : g_mid
         assign prev_e = entries[i-1];
         assign prev_s = stays[i-1];
      end
      if (i == MAX_RECORDS - 1) begin : g_last
         assign next_e = '0;
      end else begin : g_next
         assign next_e = entries[i+1];
      end
      rsk_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_entry (prev_e),
         .prev_stays (prev_s),
         .next_entry (next_e),
         .entry      (entries[i]),
         .stays      (stays[i])
      );
   end

   always_comb begin
      draining_in  = draining_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // a record that finds the chain full is lost, but the set remembers it
      if (req_take && full) begin
         overflow_in = 1'b1;
      end
      if (req_take && req_data.last_item) begin
         draining_in = 1'b1;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_take) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.sorted_key  = entries[0].key;
         rsp_data_in.sorted_tag  = entries[0].tag;
         rsp_data_in.last_out    = !entries[1].valid;
         rsp_data_in.dropped     = overflow_ff;
      end
      // set finished: chain is empty after this shift
      if (final_load) begin
         draining_in = 1'b0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff  <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         draining_ff  <= draining_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a draining set always has a record left in cell 0
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      draining_ff |-> entries[0].valid)
      else $error("drain with empty chain");

   // occupied cells stay packed at the bottom of the chain
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      !entries[0].valid |-> !entries[1].valid)
      else $error("gap in cell chain");

   // the last request of a set always starts a drain
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.last_item) |=> draining_ff)
      else $error("last request did not start drain");

   // a load of the output register shows up as a valid result
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      rsp_take |=> rsp_valid_ff)
      else $error("loaded result not presented");
`endif

endmodule

### rtl/rsk_cell.sv
// one sorting cell: holds a record, compares it with the broadcast key
module rsk_cell import rsk_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  entry_type    prev_entry,
   input  logic         prev_stays,
   input  entry_type    next_entry,
   output entry_type    entry,
   output logic         stays
);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0] tag_ff, tag_in;

   // equal keys stay in place so a newer record lands behind them
   assign stays = valid_ff && (key_ff <= ctl.key);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      tag_in   = tag_ff;
      if (ctl.shift) begin
         valid_in = next_entry.valid;
         key_in   = next_entry.key;
         tag_in   = next_entry.tag;
      end else if (ctl.insert && !stays) begin
         if (prev_stays) begin
            valid_in = 1'b1;
            key_in   = ctl.key;
            tag_in   = ctl.tag;
         end else begin
            valid_in = prev_entry.valid;
            key_in   = prev_entry.key;
            tag_in   = prev_entry.tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign entry = '{valid: valid_ff, key: key_ff, tag: tag_ff};

endmodule
